/* hdl/shp_pkg.sv */
`timescale 1ns / 1ps

package shp_pkg;

    localparam int unsigned BASE_W      = 2;
    localparam int unsigned BUDGET_W    = 4;
    localparam int unsigned COUNT_OUT_W = 10;

    typedef logic [BASE_W-1:0]   t_base;
    typedef logic [BUDGET_W-1:0] t_budget;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic shift;   // a transaction is accepted, window moves by one
        logic clear;   // that transaction ends the pair
    } t_cell_ctl;

endpackage

/* hdl/shifted_hamming_prealign_filter.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                          payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata: read_base, ref_base; tlast
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata: pass, error_count
// cfg       in         i_cfg_wr_en                        i_cfg_wr_data: error_budget
//
// one base pair per cycle while o_s_axis_tready is high; the shifted compares run in parallel across the cell row
// a result leaves through a one-deep output register, valid in the cycle after the last base is taken; base
// input is taken whenever the output register is empty or drains in the same cycle
// synchronous active-low reset clears cell valid bits, count, budget and output valid

module shifted_hamming_prealign_filter #(
    parameter int unsigned MAX_SHIFT = 15,
    parameter int unsigned MAX_LEN   = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,   // error_budget
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [1:0] read_base, [3:2] ref_base, rest zero
    input  logic        i_s_axis_tlast,  // last_base
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // [0] pass, [10:1] error_count, rest zero
);
    import shp_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

    t_budget         r_budget;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] n_total;
    logic            r_out_valid;
    logic            r_out_pass;
    logic [COUNT_OUT_W-1:0] r_out_count;
    logic [CNT_W+COUNT_OUT_W-1:0] w_count_ext;

    t_base           w_rd_in;
    t_base           w_rf_in;
    logic            w_acc;
    logic            w_err;
    t_cell_ctl       w_ctl;

    t_base           w_rd  [MAX_SHIFT];
    t_base           w_rf  [MAX_SHIFT];
    logic            w_vld [MAX_SHIFT];
    logic [MAX_SHIFT-1:0] w_kill;

    assign w_rd_in = i_s_axis_tdata[1:0];
    assign w_rf_in = i_s_axis_tdata[3:2];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ctl.shift     = w_acc;
    assign w_ctl.clear     = w_acc && i_s_axis_tlast;

    for (genvar g = 0; g < MAX_SHIFT; g++) begin : g_cell
        if (g == 0) begin : g_head
            shp_cell #(.SHIFT(g + 1)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_budget   (r_budget),
                .i_rd_cur   (w_rd_in),
                .i_rf_cur   (w_rf_in),
                .i_rd_prev  (w_rd_in),
                .i_rf_prev  (w_rf_in),
                .i_vld_prev (1'b1),
                .o_rd       (w_rd[g]),
                .o_rf       (w_rf[g]),
                .o_vld      (w_vld[g]),
                .o_kill     (w_kill[g])
            );
        end else begin : g_body
            shp_cell #(.SHIFT(g + 1)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_budget   (r_budget),
                .i_rd_cur   (w_rd_in),
                .i_rf_cur   (w_rf_in),
                .i_rd_prev  (w_rd[g-1]),
                .i_rf_prev  (w_rf[g-1]),
                .i_vld_prev (w_vld[g-1]),
                .o_rd       (w_rd[g]),
                .o_rf       (w_rf[g]),
                .o_vld      (w_vld[g]),
                .o_kill     (w_kill[g])
            );
        end
    end

    // a position is an error only if no enabled shift rescues it
    assign w_err = (w_rd_in != w_rf_in) && !(|w_kill);

    always_comb begin
        n_total = r_total;
        if (w_err && (r_total < CNT_W'(MAX_LEN))) begin
            n_total = r_total + CNT_W'(1);
        end
    end

    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, n_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= '0;
        end else if (i_cfg_wr_en) begin
            r_budget <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_acc) begin
            r_total <= i_s_axis_tlast ? '0 : n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.clear) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.clear) begin
            r_out_pass  <= (n_total <= CNT_W'(r_budget));
            r_out_count <= w_count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_count, r_out_pass};

`ifndef SYNTHESIS
    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_axis_tlast |=> r_out_valid)
        else $error("result not registered after last base");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_s_axis_tlast && !r_out_valid |=> !r_out_valid)
        else $error("result appeared without last base");

    a_total_moves_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_total))
        else $error("error count changed without a transaction");

    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_axis_tlast |=> !w_vld[0] && (r_total == '0))
        else $error("pair state not cleared after last base");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_total <= CNT_W'(MAX_LEN))
        else $error("error count above ceiling");
`endif

endmodule

/* hdl/shp_cell.sv */
`timescale 1ns / 1ps

module shp_cell #(
    parameter int unsigned SHIFT = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shp_pkg::t_cell_ctl i_ctl,
    input  shp_pkg::t_budget   i_budget,
    input  shp_pkg::t_base     i_rd_cur,
    input  shp_pkg::t_base     i_rf_cur,
    input  shp_pkg::t_base     i_rd_prev,
    input  shp_pkg::t_base     i_rf_prev,
    input  logic               i_vld_prev,
    output shp_pkg::t_base     o_rd,
    output shp_pkg::t_base     o_rf,
    output logic               o_vld,
    output logic               o_kill
);
    import shp_pkg::*;

    t_base r_rd;
    t_base r_rf;
    logic  r_vld;
    logic  w_en;

    // the cell holds the base pair seen SHIFT positions ago
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= i_ctl.clear ? 1'b0 : i_vld_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_rd <= i_rd_prev;
            r_rf <= i_rf_prev;
        end
    end

    assign w_en = (int'(i_budget) >= SHIFT);

    // shift before the start of the pair counts as a match
    assign o_kill = w_en && (!r_vld || (r_rd == i_rf_cur) || (i_rd_cur == r_rf));

    assign o_rd  = r_rd;
    assign o_rf  = r_rf;
    assign o_vld = r_vld;

endmodule
